// File: hdl/tmse_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the Turing machine step engine.
package tmse_pkg;

    localparam int TAPE_CELLS_DEF  = 65536;
    localparam int STATE_COUNT_DEF = 5;

    localparam int STATUS_W = 2;
    localparam int HEAD_W   = 18;
    localparam int MSTATE_W = 3;
    localparam int STEPS_W  = 30;
    localparam int POS_W    = 16;
    localparam int PROG_W   = 60;
    localparam int ENTRY_W  = 6;
    localparam int ENTRIES  = 10;
    localparam int IDX_W    = 4;

    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HALT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOB   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_PROGRAM_TABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_STATE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_HEAD    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRACK_CELLS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_LIMIT    = 3'd4;

    localparam logic [PROG_W-1:0]   PROGRAM_TABLE_RST = '0;
    localparam logic [MSTATE_W-1:0] START_STATE_RST   = 3'd0;
    localparam logic [POS_W-1:0]    START_HEAD_RST    = 16'd32768;
    localparam logic                TRACK_CELLS_RST   = 1'b1;
    localparam logic [STEPS_W-1:0]  STEP_LIMIT_RST    = 30'd1000000000;

    typedef struct packed {
        logic [PROG_W-1:0]   program_table;
        logic [MSTATE_W-1:0] start_state;
        logic [POS_W-1:0]    start_head;
        logic                track_cells;
        logic [STEPS_W-1:0]  step_limit;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [HEAD_W-1:0] head_position;
        logic [MSTATE_W-1:0]      machine_state;
        logic [STEPS_W-1:0]       steps_taken;
        logic [POS_W-1:0]         cell_span;
    } t_result;

    // Picks transition entry idx from the packed table; unused codes give zero.
    function automatic logic [ENTRY_W-1:0] entry_sel(
        input logic [PROG_W-1:0] table_bits,
        input logic [IDX_W-1:0]  idx
    );
        logic [ENTRY_W-1:0] sel;
        sel = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (idx == IDX_W'(k)) begin
                sel = table_bits[k*ENTRY_W +: ENTRY_W];
            end
        end
        return sel;
    endfunction

endpackage

// File: hdl/tmse_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for step items and result items.
interface tmse_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface tmse_result_if;
    logic                                    valid;
    logic                                    ready;
    logic [tmse_pkg::STATUS_W-1:0]           status;
    logic signed [tmse_pkg::HEAD_W-1:0]      head_position;
    logic [tmse_pkg::MSTATE_W-1:0]           machine_state;
    logic [tmse_pkg::STEPS_W-1:0]            steps_taken;
    logic [tmse_pkg::POS_W-1:0]              cell_span;

    modport source (output valid, output status, output head_position, output machine_state,
                    output steps_taken, output cell_span, input ready);
    modport sink   (input valid, input status, input head_position, input machine_state,
                    input steps_taken, input cell_span, output ready);
endinterface

// File: hdl/tmse_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration register bank of the step engine.
module tmse_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmse_pkg::PADDR_W-1:0]        paddr,
    input  logic [tmse_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tmse_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output tmse_pkg::t_cfg                      o_cfg
);

    tmse_pkg::t_cfg                     r_cfg;
    logic                               wr_en;
    logic [tmse_pkg::REG_IDX_W-1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[tmse_pkg::PADDR_W-1:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_table <= tmse_pkg::PROGRAM_TABLE_RST;
            r_cfg.start_state   <= tmse_pkg::START_STATE_RST;
            r_cfg.start_head    <= tmse_pkg::START_HEAD_RST;
            r_cfg.track_cells   <= tmse_pkg::TRACK_CELLS_RST;
            r_cfg.step_limit    <= tmse_pkg::STEP_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                tmse_pkg::REG_PROGRAM_TABLE: begin
                    r_cfg.program_table <= pwdata[tmse_pkg::PROG_W-1:0];
                end
                tmse_pkg::REG_START_STATE: begin
                    r_cfg.start_state <= pwdata[tmse_pkg::MSTATE_W-1:0];
                end
                tmse_pkg::REG_START_HEAD: begin
                    r_cfg.start_head <= pwdata[tmse_pkg::POS_W-1:0];
                end
                tmse_pkg::REG_TRACK_CELLS: begin
                    r_cfg.track_cells <= pwdata[0];
                end
                tmse_pkg::REG_STEP_LIMIT: begin
                    r_cfg.step_limit <= pwdata[tmse_pkg::STEPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tmse_pkg::REG_PROGRAM_TABLE: prdata = tmse_pkg::APB_DATA_W'(r_cfg.program_table);
            tmse_pkg::REG_START_STATE:   prdata = tmse_pkg::APB_DATA_W'(r_cfg.start_state);
            tmse_pkg::REG_START_HEAD:    prdata = tmse_pkg::APB_DATA_W'(r_cfg.start_head);
            tmse_pkg::REG_TRACK_CELLS:   prdata = tmse_pkg::APB_DATA_W'(r_cfg.track_cells);
            tmse_pkg::REG_STEP_LIMIT:    prdata = tmse_pkg::APB_DATA_W'(r_cfg.step_limit);
            default:                     prdata = '0;
        endcase
    end

endmodule

// File: hdl/tmse_tape_mem.sv
`timescale 1ns / 1ps
// Single-bit tape memory with registered read and a clearing pass after reset.
module tmse_tape_mem #(
    parameter int TAPE_CELLS = tmse_pkg::TAPE_CELLS_DEF,
    parameter int AW         = $clog2(TAPE_CELLS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    output logic          o_clear_busy
);

    logic          r_mem [TAPE_CELLS];
    logic          r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic          wdata;

    assign we           = r_clr_busy | i_wr_en;
    assign waddr        = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wdata        = r_clr_busy ? 1'b0 : i_wr_data;
    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(TAPE_CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hdl/tmse_out_fifo.sv
`timescale 1ns / 1ps
// Two-entry result queue between the step logic and the output channel.
module tmse_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tmse_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output tmse_pkg::t_result o_data
);

    tmse_pkg::t_result r_data [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_data[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/turing_machine_step_engine_unit.sv
`timescale 1ns / 1ps
// Each step item runs one tick of a two-symbol Turing machine (restart = 1 reloads the start
// head and state and clears the counters, keeping the tape); every item yields one result
// item. When an item is accepted, the tape bit under the head is read from the synchronous
// tape memory; in the next cycle the transition is decoded, the bit is written back and head,
// state and counters are updated, with the result pushed into the result queue. No new item is
// taken while one is being decoded. A two-entry result queue lets items keep flowing while
// results wait. After reset the tape is cleared one cell per cycle, during which no item is
// accepted; configuration writes are taken.
module turing_machine_step_engine_unit #(
    parameter int TAPE_CELLS  = tmse_pkg::TAPE_CELLS_DEF,
    parameter int STATE_COUNT = tmse_pkg::STATE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tmse_step_if.sink                       i_step,
    tmse_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmse_pkg::PADDR_W-1:0]    paddr,
    input  logic [tmse_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmse_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int AW = $clog2(TAPE_CELLS);

    tmse_pkg::t_cfg                         cfg;
    tmse_pkg::t_result                      res;
    tmse_pkg::t_result                      q_data;

    logic                                   r_busy;
    logic                                   r_restart;
    logic signed [tmse_pkg::HEAD_W-1:0]     r_head;
    logic signed [tmse_pkg::HEAD_W-1:0]     n_head;
    logic [tmse_pkg::MSTATE_W-1:0]          r_state;
    logic [tmse_pkg::MSTATE_W-1:0]          n_state;
    logic [tmse_pkg::POS_W-1:0]             r_left;
    logic [tmse_pkg::POS_W-1:0]             n_left;
    logic [tmse_pkg::POS_W-1:0]             r_right;
    logic [tmse_pkg::POS_W-1:0]             n_right;
    logic [tmse_pkg::STEPS_W-1:0]           r_steps;
    logic [tmse_pkg::STEPS_W-1:0]           n_steps;
    logic [tmse_pkg::STATUS_W-1:0]          r_status;
    logic [tmse_pkg::STATUS_W-1:0]          n_status;

    logic                                   accept;
    logic                                   clear_busy;
    logic                                   q_valid;
    logic                                   q_full;
    logic                                   pop;
    logic                                   tape_bit;
    logic                                   tape_we;
    logic                                   tape_wdata;
    logic                                   head_oob;
    logic                                   state_bad;
    logic [tmse_pkg::POS_W-1:0]             pos;
    logic [tmse_pkg::ENTRY_W-1:0]           entry;

    tmse_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tmse_tape_mem #(
        .TAPE_CELLS (TAPE_CELLS),
        .AW         (AW)
    ) u_tape (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (accept),
        .i_rd_addr    (r_head[AW-1:0]),
        .o_rd_data    (tape_bit),
        .i_wr_en      (tape_we),
        .i_wr_addr    (r_head[AW-1:0]),
        .i_wr_data    (tape_wdata),
        .o_clear_busy (clear_busy)
    );

    tmse_out_fifo u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_busy),
        .i_data  (res),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign i_step.ready = !clear_busy && !r_busy && !q_full;
    assign accept       = i_step.valid && i_step.ready;

    assign o_result.valid         = q_valid;
    assign o_result.status        = q_data.status;
    assign o_result.head_position = q_data.head_position;
    assign o_result.machine_state = q_data.machine_state;
    assign o_result.steps_taken   = q_data.steps_taken;
    assign o_result.cell_span     = q_data.cell_span;
    assign pop                    = o_result.valid && o_result.ready;

    assign head_oob  = r_head[tmse_pkg::HEAD_W-1]
                    || (r_head[tmse_pkg::HEAD_W-2:0] >= (tmse_pkg::HEAD_W-1)'(TAPE_CELLS));
    assign state_bad = (r_state >= tmse_pkg::MSTATE_W'(STATE_COUNT));
    assign pos       = r_head[tmse_pkg::POS_W-1:0];
    assign entry     = tmse_pkg::entry_sel(cfg.program_table, {r_state, tape_bit});

    always_comb begin
        n_head     = r_head;
        n_state    = r_state;
        n_left     = r_left;
        n_right    = r_right;
        n_steps    = r_steps;
        n_status   = r_status;
        tape_we    = 1'b0;
        tape_wdata = 1'b0;
        if (r_busy) begin
            if (r_restart) begin
                n_head   = tmse_pkg::HEAD_W'(cfg.start_head);
                n_state  = cfg.start_state;
                n_left   = cfg.start_head;
                n_right  = cfg.start_head;
                n_steps  = '0;
                n_status = tmse_pkg::ST_RUN;
            end else if (r_status == tmse_pkg::ST_RUN) begin
                if (r_steps >= cfg.step_limit) begin
                    n_status = tmse_pkg::ST_LIMIT;
                end else if (head_oob) begin
                    n_status = tmse_pkg::ST_OOB;
                end else begin
                    if (cfg.track_cells) begin
                        if (pos < r_left) begin
                            n_left = pos;
                        end
                        if (pos > r_right) begin
                            n_right = pos;
                        end
                    end
                    if (state_bad || entry[5]) begin
                        n_status = tmse_pkg::ST_HALT;
                    end else begin
                        tape_we    = 1'b1;
                        tape_wdata = entry[0];
                        n_state    = entry[4:2];
                        n_head     = entry[1] ? (r_head + 18'sd1) : (r_head - 18'sd1);
                        n_steps    = r_steps + tmse_pkg::STEPS_W'(1);
                        if (n_steps >= cfg.step_limit) begin
                            n_status = tmse_pkg::ST_LIMIT;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        res.status        = n_status;
        res.head_position = n_head;
        res.machine_state = n_state;
        res.steps_taken   = n_steps;
        res.cell_span     = cfg.track_cells ? (n_right - n_left) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_restart <= 1'b0;
            r_head    <= tmse_pkg::HEAD_W'(tmse_pkg::START_HEAD_RST);
            r_state   <= tmse_pkg::START_STATE_RST;
            r_left    <= tmse_pkg::START_HEAD_RST;
            r_right   <= tmse_pkg::START_HEAD_RST;
            r_steps   <= '0;
            r_status  <= tmse_pkg::ST_RUN;
        end else begin
            r_busy    <= accept;
            r_restart <= accept ? i_step.restart : r_restart;
            r_head    <= n_head;
            r_state   <= n_state;
            r_left    <= n_left;
            r_right   <= n_right;
            r_steps   <= n_steps;
            r_status  <= n_status;
        end
    end

    a_tape_write_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tape_we |-> (!head_oob && !clear_busy && r_status == tmse_pkg::ST_RUN))
        else $error("tape written outside a running in-bounds step");

    a_steps_advance_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_steps == $past(r_steps) || r_steps == '0
                    || r_steps == $past(r_steps) + tmse_pkg::STEPS_W'(1)))
        else $error("step counter moved by more than one step");

    a_stop_is_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != tmse_pkg::ST_RUN && !(r_busy && r_restart))
        |=> (r_status == $past(r_status)))
        else $error("stopped machine left its status without a restart");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (!q_full || pop))
        else $error("result pushed into a full queue");

endmodule

// File: verif/turing_machine_step_engine_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Turing machine step engine against a behavioural machine model.
module turing_machine_step_engine_unit_test;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int ENT_WRITE = 0;
    localparam int ENT_RIGHT = 1;
    localparam int ENT_HALT  = 5;
    localparam logic [tmse_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [tmse_pkg::PADDR_W-1:0] paddr;
    logic [tmse_pkg::APB_DATA_W-1:0] pwdata;
    logic [tmse_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    tmse_step_if   step_bus ();
    tmse_result_if res_bus ();

    turing_machine_step_engine_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_bus),
        .o_result (res_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    tmse_pkg::t_cfg                model_cfg;
    bit                            tape_img [tmse_pkg::TAPE_CELLS_DEF];
    int                            head_pos;
    logic [tmse_pkg::MSTATE_W-1:0] mach_state;
    int                            left_pos;
    int                            right_pos;
    logic [tmse_pkg::STEPS_W-1:0]  step_count;
    logic [tmse_pkg::STATUS_W-1:0] run_state;

    tmse_pkg::t_result pending_results [$];
    int                mismatch_count;
    bit                steady_flow;

    function automatic void reload_machine();
        head_pos   = int'(model_cfg.start_head);
        mach_state = model_cfg.start_state;
        left_pos   = int'(model_cfg.start_head);
        right_pos  = int'(model_cfg.start_head);
        step_count = '0;
        run_state  = tmse_pkg::ST_RUN;
    endfunction

    function automatic tmse_pkg::t_result machine_tick(input logic restart_bit);
        tmse_pkg::t_result            r;
        int                           pos;
        logic [tmse_pkg::IDX_W-1:0]   slot;
        logic [tmse_pkg::ENTRY_W-1:0] entry;
        if (restart_bit) begin
            reload_machine();
        end else if (run_state == tmse_pkg::ST_RUN) begin
            if (step_count >= model_cfg.step_limit) begin
                run_state = tmse_pkg::ST_LIMIT;
            end else if (head_pos < 0 || head_pos >= tmse_pkg::TAPE_CELLS_DEF) begin
                run_state = tmse_pkg::ST_OOB;
            end else begin
                pos = head_pos;
                if (model_cfg.track_cells) begin
                    if (pos < left_pos) begin
                        left_pos = pos;
                    end
                    if (pos > right_pos) begin
                        right_pos = pos;
                    end
                end
                if (mach_state >= tmse_pkg::STATE_COUNT_DEF) begin
                    run_state = tmse_pkg::ST_HALT;
                end else begin
                    slot  = tmse_pkg::IDX_W'(mach_state * 2 + tape_img[pos]);
                    entry = model_cfg.program_table[slot*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W];
                    if (entry[ENT_HALT]) begin
                        run_state = tmse_pkg::ST_HALT;
                    end else begin
                        tape_img[pos] = entry[ENT_WRITE];
                        mach_state    = entry[4:2];
                        head_pos      = entry[ENT_RIGHT] ? head_pos + 1 : head_pos - 1;
                        step_count    = step_count + 1'b1;
                        if (step_count >= model_cfg.step_limit) begin
                            run_state = tmse_pkg::ST_LIMIT;
                        end
                    end
                end
            end
        end
        r.status        = run_state;
        r.head_position = tmse_pkg::HEAD_W'(head_pos);
        r.machine_state = mach_state;
        r.steps_taken   = step_count;
        r.cell_span     = model_cfg.track_cells ? tmse_pkg::POS_W'(right_pos - left_pos) : '0;
        return r;
    endfunction

    function automatic logic [tmse_pkg::ENTRY_W-1:0] make_entry(input logic halt,
                                                                input int next,
                                                                input logic right,
                                                                input logic wbit);
        return {halt, tmse_pkg::MSTATE_W'(next), right, wbit};
    endfunction

    function automatic logic [tmse_pkg::PROG_W-1:0] fill_table(
        input logic [tmse_pkg::ENTRY_W-1:0] entry
    );
        logic [tmse_pkg::PROG_W-1:0] t;
        for (int k = 0; k < tmse_pkg::ENTRIES; k++) begin
            t[k*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W] = entry;
        end
        return t;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic write_reg(input logic [tmse_pkg::REG_IDX_W-1:0] idx,
                             input logic [tmse_pkg::APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            tmse_pkg::REG_PROGRAM_TABLE:
                model_cfg.program_table = value[tmse_pkg::PROG_W-1:0];
            tmse_pkg::REG_START_STATE:
                model_cfg.start_state = value[tmse_pkg::MSTATE_W-1:0];
            tmse_pkg::REG_START_HEAD:
                model_cfg.start_head = value[tmse_pkg::POS_W-1:0];
            tmse_pkg::REG_TRACK_CELLS:
                model_cfg.track_cells = value[0];
            tmse_pkg::REG_STEP_LIMIT:
                model_cfg.step_limit = value[tmse_pkg::STEPS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_step(input logic restart_bit);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            step_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        step_bus.valid   <= 1'b1;
        step_bus.restart <= restart_bit;
        do @(posedge i_clk); while (!(step_bus.valid && step_bus.ready));
        pending_results.push_back(machine_tick(restart_bit));
    endtask

    task automatic settle();
        @(negedge i_clk);
        step_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic compare_field(input string label, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_reset_defaults();
        repeat (3) send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
    endtask

    task automatic test_halts();
        logic [tmse_pkg::PROG_W-1:0] t;
        settle();
        t = '0;
        t[0*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W] = make_entry(1'b0, 1, 1'b1, 1'b1);
        t[1*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W] = make_entry(1'b0, 1, 1'b1, 1'b1);
        t[2*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W] = make_entry(1'b1, 0, 1'b0, 1'b0);
        t[3*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W] = make_entry(1'b1, 0, 1'b0, 1'b0);
        write_reg(tmse_pkg::REG_PROGRAM_TABLE, tmse_pkg::APB_DATA_W'(t));
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);
        // A start state beyond the last valid one behaves as a halting entry.
        settle();
        write_reg(tmse_pkg::REG_START_STATE, 64'd7);
        send_step(1'b1);
        send_step(1'b0);
        // So does a next state beyond the last valid one.
        settle();
        write_reg(tmse_pkg::REG_START_STATE, 64'd4);
        write_reg(tmse_pkg::REG_PROGRAM_TABLE,
                  tmse_pkg::APB_DATA_W'(fill_table(make_entry(1'b0, 6, 1'b1, 1'b1))));
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
    endtask

    task automatic test_tape_edges();
        settle();
        write_reg(tmse_pkg::REG_START_STATE, 64'd0);
        write_reg(tmse_pkg::REG_START_HEAD, 64'd0);
        write_reg(tmse_pkg::REG_PROGRAM_TABLE,
                  tmse_pkg::APB_DATA_W'(fill_table(make_entry(1'b0, 2, 1'b0, 1'b1))));
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);
        settle();
        write_reg(tmse_pkg::REG_START_HEAD, 64'd65535);
        write_reg(tmse_pkg::REG_PROGRAM_TABLE,
                  tmse_pkg::APB_DATA_W'(fill_table(make_entry(1'b0, 3, 1'b1, 1'b0))));
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
    endtask

    task automatic test_step_limit();
        settle();
        write_reg(tmse_pkg::REG_START_HEAD, 64'd32768);
        write_reg(tmse_pkg::REG_STEP_LIMIT, 64'd1);
        send_step(1'b1);
        send_step(1'b0);
        settle();
        write_reg(tmse_pkg::REG_STEP_LIMIT, 64'd0);
        send_step(1'b1);
        send_step(1'b0);
        // Lowering the limit below the count stops the machine on the next step.
        settle();
        write_reg(tmse_pkg::REG_STEP_LIMIT, 64'h3FFF_FFFF);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        settle();
        write_reg(tmse_pkg::REG_STEP_LIMIT, 64'd2);
        send_step(1'b0);
    endtask

    task automatic test_tracking_off();
        settle();
        write_reg(tmse_pkg::REG_STEP_LIMIT, tmse_pkg::APB_DATA_W'(tmse_pkg::STEP_LIMIT_RST));
        write_reg(tmse_pkg::REG_TRACK_CELLS, 64'd0);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        settle();
        write_reg(tmse_pkg::REG_TRACK_CELLS, 64'd1);
        write_reg(REG_UNUSED, '1);
        send_step(1'b0);
    endtask

    task automatic test_random_programs();
        logic [tmse_pkg::PROG_W-1:0] t;
        logic [tmse_pkg::MSTATE_W-1:0] st;
        logic [tmse_pkg::POS_W-1:0] hd;
        logic [tmse_pkg::STEPS_W-1:0] lim;
        int items;
        for (int phase = 0; phase < 20; phase++) begin
            settle();
            case ($urandom_range(0, 9))
                0: t = '0;
                1: t = '1;
                2: t = tmse_pkg::PROG_W'({$urandom, $urandom});
                default: begin
                    for (int k = 0; k < tmse_pkg::ENTRIES; k++) begin
                        t[k*tmse_pkg::ENTRY_W +: tmse_pkg::ENTRY_W] = make_entry(
                            $urandom_range(0, 15) == 0,
                            ($urandom_range(0, 31) == 0) ? $urandom_range(5, 7)
                                                         : $urandom_range(0, 4),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                end
            endcase
            st = tmse_pkg::MSTATE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                                 : $urandom_range(0, 4));
            case ($urandom_range(0, 4))
                0: hd = tmse_pkg::POS_W'($urandom_range(0, 3));
                1: hd = tmse_pkg::POS_W'($urandom_range(65532, 65535));
                2: hd = tmse_pkg::START_HEAD_RST;
                default: hd = tmse_pkg::POS_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 7))
                0: lim = '0;
                1: lim = tmse_pkg::STEP_LIMIT_RST;
                2: lim = '1;
                3: lim = tmse_pkg::STEPS_W'($urandom);
                default: lim = tmse_pkg::STEPS_W'($urandom_range(1, 60));
            endcase
            write_reg(tmse_pkg::REG_PROGRAM_TABLE, tmse_pkg::APB_DATA_W'(t));
            write_reg(tmse_pkg::REG_START_STATE, tmse_pkg::APB_DATA_W'(st));
            write_reg(tmse_pkg::REG_START_HEAD, tmse_pkg::APB_DATA_W'(hd));
            write_reg(tmse_pkg::REG_TRACK_CELLS,
                      tmse_pkg::APB_DATA_W'($urandom_range(0, 3) != 0));
            write_reg(tmse_pkg::REG_STEP_LIMIT, tmse_pkg::APB_DATA_W'(lim));
            steady_flow = (phase % 5 == 4);
            send_step(1'b1);
            items = $urandom_range(40, 60);
            repeat (items) send_step($urandom_range(0, 11) == 0);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        int stall;
        stall = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_flow) begin
                res_bus.ready <= 1'b1;
            end else if (stall > 0) begin
                res_bus.ready <= 1'b0;
                stall--;
            end else begin
                res_bus.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        tmse_pkg::t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item arrived with nothing expected", $time);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, res_bus.status);
                compare_field("head_position", want.head_position, res_bus.head_position);
                compare_field("machine_state", want.machine_state, res_bus.machine_state);
                compare_field("steps_taken", want.steps_taken, res_bus.steps_taken);
                compare_field("cell_span", want.cell_span, res_bus.cell_span);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((step_bus.valid && step_bus.ready) || (res_bus.valid && res_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        steady_flow    = 1'b0;
        model_cfg.program_table = tmse_pkg::PROGRAM_TABLE_RST;
        model_cfg.start_state   = tmse_pkg::START_STATE_RST;
        model_cfg.start_head    = tmse_pkg::START_HEAD_RST;
        model_cfg.track_cells   = tmse_pkg::TRACK_CELLS_RST;
        model_cfg.step_limit    = tmse_pkg::STEP_LIMIT_RST;
        foreach (tape_img[k]) begin
            tape_img[k] = 1'b0;
        end
        reload_machine();
        i_rst_n          = 1'b0;
        step_bus.valid   = 1'b0;
        step_bus.restart = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_halts();
        test_tape_edges();
        test_step_limit();
        test_tracking_off();
        test_random_programs();

        settle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/tmse_pkg.sv
hdl/tmse_ifs.sv
hdl/tmse_cfg_regs.sv
hdl/tmse_tape_mem.sv
hdl/tmse_out_fifo.sv
hdl/turing_machine_step_engine_unit.sv
verif/turing_machine_step_engine_unit_test.sv
